// ===== design/websocket_short_frame_handler_macros.svh =====
// Assertion macros for the websocket short frame handler.
`ifndef WEBSOCKET_SHORT_FRAME_HANDLER_MACROS_SVH
`define WEBSOCKET_SHORT_FRAME_HANDLER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked property, disabled while reset is high.
`define WSF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define WSF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define WSF_ASSERT(label, clk, rst, prop, msg)
`define WSF_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== design/wsf_pkg.sv =====
`timescale 1ns / 1ps

package wsf_pkg;

  localparam logic [6:0] LONG_LENGTH_CODE = 7'd126;

  localparam logic [2:0] VERDICT_IGNORE  = 3'd0;
  localparam logic [2:0] VERDICT_CLOSE   = 3'd1;
  localparam logic [2:0] VERDICT_REPLY   = 3'd2;
  localparam logic [2:0] VERDICT_FORWARD = 3'd3;
  localparam logic [2:0] VERDICT_ERROR   = 3'd4;

  localparam logic [3:0] OPCODE_CLOSE = 4'h8;
  localparam logic [3:0] OPCODE_PING  = 4'h9;
  localparam logic [3:0] OPCODE_PONG  = 4'hA;
  localparam logic [7:0] FLAGS_BINARY_FINAL = 8'h82;

  localparam logic [7:0] POS_LENGTH     = 8'd1;
  localparam logic [7:0] POS_PAYLOAD    = 8'd6;
  localparam logic [7:0] POS_SATURATED  = 8'd255;
  localparam logic [8:0] HEADER_BYTES   = 9'd6;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       frame_done;
    logic [2:0] verdict;
  } wsf_result_t;

endpackage

// ===== design/wsf_rx_if.sv =====
`timescale 1ns / 1ps

interface wsf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rx_last;

  modport source (output valid, output rx_byte, output rx_last, input ready);
  modport sink (input valid, input rx_byte, input rx_last, output ready);
endinterface

// ===== design/wsf_tx_if.sv =====
`timescale 1ns / 1ps

interface wsf_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_valid;
  logic       frame_done;
  logic [2:0] verdict;

  modport source (output valid, output tx_byte, output tx_valid, output frame_done,
                  output verdict, input ready);
  modport sink (input valid, input tx_byte, input tx_valid, input frame_done,
                input verdict, output ready);
endinterface

// ===== design/wsf_decode.sv =====
`timescale 1ns / 1ps
`include "websocket_short_frame_handler_macros.svh"

module wsf_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         rx_byte,
  input  logic               rx_last,
  output logic               emit,
  output wsf_pkg::wsf_result_t result
);

  logic [7:0]  byte_position;
  logic [7:0]  flags_seen;
  logic [6:0]  payload_length;
  logic [31:0] mask_key;
  logic        error_seen;

  logic [7:0]  payload_index;
  logic [8:0]  total;
  logic [7:0]  mask_byte;
  logic [2:0]  verdict_next;

  assign payload_index = byte_position - wsf_pkg::POS_PAYLOAD;
  assign total = {1'b0, byte_position} + 9'd1;

  always_comb begin
    case (payload_index[1:0])
      2'd0:    mask_byte = mask_key[7:0];
      2'd1:    mask_byte = mask_key[15:8];
      2'd2:    mask_byte = mask_key[23:16];
      default: mask_byte = mask_key[31:24];
    endcase
  end

  always_comb begin
    if (total < wsf_pkg::HEADER_BYTES || error_seen ||
        {2'b00, payload_length} != total - wsf_pkg::HEADER_BYTES) begin
      verdict_next = wsf_pkg::VERDICT_ERROR;
    end else if (flags_seen[3]) begin
      case (flags_seen[3:0])
        wsf_pkg::OPCODE_CLOSE: verdict_next = wsf_pkg::VERDICT_CLOSE;
        wsf_pkg::OPCODE_PING:  verdict_next = wsf_pkg::VERDICT_REPLY;
        wsf_pkg::OPCODE_PONG:  verdict_next = wsf_pkg::VERDICT_IGNORE;
        default:               verdict_next = wsf_pkg::VERDICT_ERROR;
      endcase
    end else if (flags_seen == wsf_pkg::FLAGS_BINARY_FINAL) begin
      verdict_next = wsf_pkg::VERDICT_FORWARD;
    end else begin
      verdict_next = wsf_pkg::VERDICT_ERROR;
    end
  end

  always_comb begin
    result = '0;
    if (byte_position == 8'd0) begin
      result.tx_valid = 1'b1;
      if (rx_byte[3] && rx_byte[3:0] == wsf_pkg::OPCODE_PING) begin
        result.tx_byte = {rx_byte[7:4], wsf_pkg::OPCODE_PONG};
      end else begin
        result.tx_byte = rx_byte;
      end
    end else if (byte_position == wsf_pkg::POS_LENGTH) begin
      result.tx_valid = 1'b1;
      result.tx_byte  = {1'b0, rx_byte[6:0]};
    end else if (byte_position >= wsf_pkg::POS_PAYLOAD &&
                 payload_index < {1'b0, payload_length}) begin
      result.tx_valid = 1'b1;
      result.tx_byte  = rx_byte ^ mask_byte;
    end
    if (rx_last) begin
      result.frame_done = 1'b1;
      result.verdict    = verdict_next;
    end
  end

  assign emit = result.tx_valid || result.frame_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      flags_seen     <= '0;
      payload_length <= '0;
      mask_key       <= '0;
      error_seen     <= 1'b0;
    end else if (accept) begin
      if (rx_last) begin
        byte_position  <= '0;
        flags_seen     <= '0;
        payload_length <= '0;
        mask_key       <= '0;
        error_seen     <= 1'b0;
      end else begin
        case (byte_position)
          8'd0: flags_seen <= rx_byte;
          8'd1: begin
            payload_length <= rx_byte[6:0];
            error_seen     <= (rx_byte[6:0] >= wsf_pkg::LONG_LENGTH_CODE);
          end
          8'd2: mask_key[7:0]   <= rx_byte;
          8'd3: mask_key[15:8]  <= rx_byte;
          8'd4: mask_key[23:16] <= rx_byte;
          8'd5: mask_key[31:24] <= rx_byte;
          default: ;
        endcase
        if (byte_position != wsf_pkg::POS_SATURATED) begin
          byte_position <= byte_position + 8'd1;
        end
      end
    end
  end

  `WSF_ASSERT(a_pos_clear_after_last, clk, rst,
    (accept && rx_last) |=> (byte_position == 8'd0 && error_seen == 1'b0),
    "frame state not cleared after last byte")

  `WSF_ASSERT(a_pos_advance, clk, rst,
    (accept && !rx_last && byte_position != wsf_pkg::POS_SATURATED) |=>
      (byte_position == $past(byte_position) + 8'd1),
    "byte position did not advance")

  `WSF_ASSERT(a_verdict_only_when_done, clk, rst,
    (!result.frame_done) |-> (result.verdict == wsf_pkg::VERDICT_IGNORE),
    "verdict set without frame end")

  `WSF_ASSERT(a_mask_bytes_silent, clk, rst,
    (byte_position >= 8'd2 && byte_position < wsf_pkg::POS_PAYLOAD) |->
      !result.tx_valid,
    "mask byte produced output")

endmodule

// ===== design/wsf_out_reg.sv =====
`timescale 1ns / 1ps
`include "websocket_short_frame_handler_macros.svh"

module wsf_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 load,
  input  wsf_pkg::wsf_result_t in_result,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wsf_pkg::wsf_result_t out_result
);

  logic                 valid;
  wsf_pkg::wsf_result_t data;

  assign in_ready   = !valid || out_ready;
  assign out_valid  = valid;
  assign out_result = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid && load;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid && load) begin
      data <= in_result;
    end
  end

  `WSF_ASSERT(a_load_sets_valid, clk, rst,
    (in_valid && in_ready && load) |=> valid,
    "loaded transfer not held")

  `WSF_ASSERT(a_silent_item_drains, clk, rst,
    (in_valid && in_ready && !load) |=> !valid,
    "stale result after item without output")

  `WSF_ASSERT_ALWAYS(a_reset_empty, clk,
    rst |=> !valid,
    "output register not empty after reset")

endmodule

// ===== design/websocket_short_frame_handler.sv =====
`timescale 1ns / 1ps
// WebSocket short frame handler.
// rx: one received client frame byte per transfer (rx_byte, rx_last marks the
//   final byte of the message). Wire order: flags, length, four mask bytes,
//   payload of up to 125 bytes.
// tx: one transfer per outgoing byte and/or frame end. tx_valid marks a frame
//   byte (flags with ping rewritten to pong, 7-bit length, unmasked payload);
//   frame_done marks the result of the last input byte and carries verdict:
//   0 ignore, 1 reply then close, 2 reply, 3 forward, 4 error. Mask bytes and
//   surplus payload bytes not marked last produce no transfer.
// Each result is registered: it appears on tx in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless tx stalls, set by the single output
//   register; the decode logic between frame state and register is one short pass.
// Stall: while a result waits on tx.ready, rx.ready is low; when tx.ready is
//   high a new byte is taken in the same cycle the held result leaves.
// Reset (rst, synchronous): frame state clears to the start of a frame and
//   the output register empties.
module websocket_short_frame_handler (
  input  logic clk,
  input  logic rst,
  wsf_rx_if.sink   rx,
  wsf_tx_if.source tx
);

  logic                 accept;
  logic                 emit;
  logic                 in_ready;
  wsf_pkg::wsf_result_t result;
  wsf_pkg::wsf_result_t out_result;

  assign rx.ready = in_ready;
  assign accept   = rx.valid && in_ready;

  wsf_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx.rx_byte),
    .rx_last (rx.rx_last),
    .emit    (emit),
    .result  (result)
  );

  wsf_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rx.valid),
    .in_ready   (in_ready),
    .load       (emit),
    .in_result  (result),
    .out_valid  (tx.valid),
    .out_ready  (tx.ready),
    .out_result (out_result)
  );

  assign tx.tx_byte    = out_result.tx_byte;
  assign tx.tx_valid   = out_result.tx_valid;
  assign tx.frame_done = out_result.frame_done;
  assign tx.verdict    = out_result.verdict;

endmodule

// ===== bench/websocket_short_frame_handler_test.sv =====
`timescale 1ns / 1ps

module websocket_short_frame_handler_test;

  localparam int FRAME_ITEMS      = 775;
  localparam int QUIET_AFTER      = 650;
  localparam int HOLD_AFTER       = 250;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int STALL_LIMIT      = 1000;
  localparam int DRAIN_CYCLES     = 8;

  typedef enum int {FRAME_RANDOM, FRAME_LONG_MESSAGE, FRAME_OVERLONG_EXACT} frame_shape_t;

  typedef struct packed {
    logic [7:0]           rx_byte;
    logic                 rx_last;
    logic                 typed;
    wsf_pkg::wsf_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  wsf_rx_if rx_ch ();
  wsf_tx_if tx_ch ();

  websocket_short_frame_handler uut (
    .clk(clk),
    .rst(rst),
    .rx (rx_ch),
    .tx (tx_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  frame_pos;
  logic [7:0]  frame_flags;
  logic [6:0]  declared_len;
  logic [31:0] mask_word;
  logic        len_too_long;

  wsf_pkg::wsf_result_t expected_tx_q[$];
  int          items_sent;
  int          check_failures;
  int          stall_cycles;
  int          rx_gap_pct;
  int          tx_gap_pct;
  bit          quiet;
  bit          hold_request;
  bit          hold_done;

  // first byte alone, empty ping, close with one byte, overlong pong, binary
  stim_row_t directed_rows [24] = '{
    '{8'h89, 1'b1, 1'b1, '{8'h8A, 1'b1, 1'b1, wsf_pkg::VERDICT_ERROR}},
    '{8'h89, 1'b0, 1'b1, '{8'h8A, 1'b1, 1'b0, '0}},
    '{8'h80, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, '0}},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, wsf_pkg::VERDICT_REPLY}},
    '{8'h88, 1'b0, 1'b1, '{8'h88, 1'b1, 1'b0, '0}},
    '{8'h81, 1'b0, 1'b1, '{8'h01, 1'b1, 1'b0, '0}},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, wsf_pkg::VERDICT_CLOSE}},
    '{8'h8A, 1'b0, 1'b1, '{8'h8A, 1'b1, 1'b0, '0}},
    '{8'hFE, 1'b1, 1'b1, '{8'h7E, 1'b1, 1'b1, wsf_pkg::VERDICT_ERROR}},
    '{8'h82, 1'b0, 1'b1, '{8'h82, 1'b1, 1'b0, '0}},
    '{8'h82, 1'b0, 1'b0, '0},
    '{8'h12, 1'b0, 1'b0, '0},
    '{8'h34, 1'b0, 1'b0, '0},
    '{8'h56, 1'b0, 1'b0, '0},
    '{8'h78, 1'b0, 1'b0, '0},
    '{8'hAB, 1'b0, 1'b0, '0},
    '{8'hCD, 1'b1, 1'b0, '0}
  };

  function automatic bit predict_frame_byte(input logic [7:0] b, input logic last,
                                            output wsf_pkg::wsf_result_t r);
    logic [8:0]  total;
    logic [7:0]  idx;
    logic [31:0] key;
    r = '0;
    if (frame_pos == '0) begin
      frame_flags = b;
      r.tx_byte = (b[3] && b[3:0] == wsf_pkg::OPCODE_PING) ?
                  {b[7:4], wsf_pkg::OPCODE_PONG} : b;
      r.tx_valid = 1'b1;
    end else if (frame_pos == wsf_pkg::POS_LENGTH) begin
      declared_len = b[6:0];
      if (b[6:0] >= wsf_pkg::LONG_LENGTH_CODE) len_too_long = 1'b1;
      r.tx_byte = {1'b0, b[6:0]};
      r.tx_valid = 1'b1;
    end else if (frame_pos < wsf_pkg::POS_PAYLOAD) begin
      mask_word |= {24'd0, b} << (8 * (frame_pos - 8'd2));
    end else begin
      idx = frame_pos - wsf_pkg::POS_PAYLOAD;
      if (idx < {1'b0, declared_len}) begin
        key = mask_word >> (8 * idx[1:0]);
        r.tx_byte = b ^ key[7:0];
        r.tx_valid = 1'b1;
      end
    end
    if (last) begin
      total = {1'b0, frame_pos} + 9'd1;
      r.frame_done = 1'b1;
      if (total < wsf_pkg::HEADER_BYTES || len_too_long ||
          {2'b0, declared_len} != total - wsf_pkg::HEADER_BYTES)
        r.verdict = wsf_pkg::VERDICT_ERROR;
      else if (frame_flags[3]) begin
        case (frame_flags[3:0])
          wsf_pkg::OPCODE_CLOSE: r.verdict = wsf_pkg::VERDICT_CLOSE;
          wsf_pkg::OPCODE_PING:  r.verdict = wsf_pkg::VERDICT_REPLY;
          wsf_pkg::OPCODE_PONG:  r.verdict = wsf_pkg::VERDICT_IGNORE;
          default:               r.verdict = wsf_pkg::VERDICT_ERROR;
        endcase
      end else begin
        r.verdict = (frame_flags == wsf_pkg::FLAGS_BINARY_FINAL) ?
                    wsf_pkg::VERDICT_FORWARD : wsf_pkg::VERDICT_ERROR;
      end
      frame_pos = '0;
      frame_flags = '0;
      declared_len = '0;
      mask_word = '0;
      len_too_long = 1'b0;
    end else if (frame_pos < wsf_pkg::POS_SATURATED) begin
      frame_pos = frame_pos + 8'd1;
    end
    return r.tx_valid || last;
  endfunction

  function automatic int pick_gap_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input wsf_pkg::wsf_result_t typed_res);
    wsf_pkg::wsf_result_t r;
    bit has_result;
    if (!quiet && $urandom_range(0, 99) < rx_gap_pct) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    rx_ch.rx_last <= last;
    do @(posedge clk); while (!rx_ch.ready);
    has_result = predict_frame_byte(b, last, r);
    if (typed) expected_tx_q.push_back(typed_res);
    else if (has_result) expected_tx_q.push_back(r);
    items_sent++;
  endtask

  task automatic send_random_frame(input frame_shape_t shape);
    logic [7:0] flags;
    logic [7:0] b;
    logic [6:0] len;
    int n_bytes;
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: flags = wsf_pkg::FLAGS_BINARY_FINAL;
      4: flags = {4'($urandom), wsf_pkg::OPCODE_CLOSE};
      5: flags = {4'($urandom), wsf_pkg::OPCODE_PING};
      6: flags = {4'($urandom), wsf_pkg::OPCODE_PONG};
      7: flags = {4'($urandom), 1'b1, 3'($urandom_range(3, 7))};
      default: flags = 8'($urandom);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 85) len = 7'($urandom_range(0, 8));
    else if (pick < 97) len = 7'($urandom_range(9, 125));
    else len = 7'($urandom_range(126, 127));
    pick = $urandom_range(0, 99);
    if (pick < 80) n_bytes = 6 + len;
    else if (pick < 90) n_bytes = 6 + len + $urandom_range(1, 3);
    else if (pick < 95) n_bytes = (len == 0) ? 7 : 5 + len;
    else n_bytes = $urandom_range(1, 6);
    case (shape)
      FRAME_LONG_MESSAGE: n_bytes = $urandom_range(258, 264);
      FRAME_OVERLONG_EXACT: begin
        len = wsf_pkg::LONG_LENGTH_CODE;
        n_bytes = 6 + len;
      end
      default: ;
    endcase
    for (int i = 0; i < n_bytes; i++) begin
      if (i == 0) b = flags;
      else if (i == 1) b = {1'($urandom), len};
      else b = 8'($urandom);
      send_byte(b, i == n_bytes - 1, 1'b0, '0);
    end
  endtask

  // receiver side: random stalls plus one long hold-off
  initial begin
    forever begin
      if ($urandom_range(0, 63) == 0) tx_gap_pct = pick_gap_pct();
      if (hold_request) begin
        tx_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < tx_gap_pct) begin
        tx_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        tx_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    wsf_pkg::wsf_result_t exp_res;
    if (!rst) begin
      if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready)) stall_cycles = 0;
      else stall_cycles++;
      if (tx_ch.valid && tx_ch.ready) begin
        if (expected_tx_q.size() == 0) begin
          check_failures++;
          if (check_failures <= 10)
            $display("unexpected transfer: byte %h valid %b done %b verdict %0d",
                     tx_ch.tx_byte, tx_ch.tx_valid, tx_ch.frame_done, tx_ch.verdict);
        end else begin
          exp_res = expected_tx_q.pop_front();
          if (tx_ch.tx_byte !== exp_res.tx_byte || tx_ch.tx_valid !== exp_res.tx_valid ||
              tx_ch.frame_done !== exp_res.frame_done || tx_ch.verdict !== exp_res.verdict) begin
            check_failures++;
            if (check_failures <= 10)
              $display("mismatch: exp byte %h v %b d %b vd %0d, got byte %h v %b d %b vd %0d",
                       exp_res.tx_byte, exp_res.tx_valid, exp_res.frame_done, exp_res.verdict,
                       tx_ch.tx_byte, tx_ch.tx_valid, tx_ch.frame_done, tx_ch.verdict);
          end
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int frame_count;
    rst <= 1'b1;
    rx_ch.valid <= 1'b0;
    rx_ch.rx_byte <= '0;
    rx_ch.rx_last <= 1'b0;
    frame_pos = '0;
    frame_flags = '0;
    declared_len = '0;
    mask_word = '0;
    len_too_long = 1'b0;
    items_sent = 0;
    check_failures = 0;
    stall_cycles = 0;
    rx_gap_pct = 0;
    tx_gap_pct = 0;
    quiet = 1'b0;
    hold_request = 1'b0;
    hold_done = 1'b0;
    frame_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].rx_byte, directed_rows[i].rx_last, directed_rows[i].typed,
                directed_rows[i].res);

    while (items_sent < FRAME_ITEMS) begin
      if (items_sent >= QUIET_AFTER) quiet = 1'b1;
      if (!hold_done && items_sent >= HOLD_AFTER) begin
        hold_request = 1'b1;
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 7) == 0) rx_gap_pct = pick_gap_pct();
      if (frame_count == 12) send_random_frame(FRAME_LONG_MESSAGE);
      else if (frame_count == 4) send_random_frame(FRAME_OVERLONG_EXACT);
      else send_random_frame(FRAME_RANDOM);
      frame_count++;
    end
    rx_ch.valid <= 1'b0;

    while (expected_tx_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (check_failures == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
